// File: rtl/core/sws_pkg.sv
package sws_pkg;

    // command codes of the input word
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ALARM = 2'd1,
        CMD_POWER = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // power action codes of the result word
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_ON   = 2'd1,
        ACT_OFF  = 2'd2
    } action_t;

    localparam logic [15:0] ENTRY_END      = 16'hFFFF;
    localparam logic [15:0] ENTRY_MIDNIGHT = 16'h2400;
    localparam logic [14:0] YEAR_MAX       = 15'd9999;
    localparam int          DAYS           = 7;

    // classified input word, as queued between front and back
    typedef struct packed {
        cmd_t        cmd;
        logic        wr_ok;
        logic [2:0]  day;
        logic [3:0]  slot;
        logic [15:0] value;
        logic [2:0]  weekday;
        logic [15:0] cur;
        logic [4:0]  dday;
        logic [3:0]  month;
        logic [13:0] year;
        logic        leap;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        no_sched;
    } result_t;

endpackage

// File: rtl/core/weekly_schedule_switch.sv
// A write or a no-op command goes from idle straight to the output state, which raises its result word.
// Alarm and power-up read the table through one registered RAM port, a read state and
// an evaluate state per entry: first the day's row, then the other-day search over up
// to 13 days, then the date state and the output state.
// The back end takes one word per such pass and waits while a result is stalled; a 2-word queue takes input meanwhile.
// Reset clears all entry valid bits at once; no clearing pass.
module weekly_schedule_switch #(
    parameter int SLOTS_PER_DAY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [2:0]  s_entry_day,
    input  logic [3:0]  s_entry_slot,
    input  logic [15:0] s_entry_value,
    input  logic [2:0]  s_now_weekday,
    input  logic [4:0]  s_now_hour,
    input  logic [5:0]  s_now_minute,
    input  logic [4:0]  s_date_day,
    input  logic [3:0]  s_date_month,
    input  logic [13:0] s_date_year,
    input  logic        s_leap_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_power_action,
    output logic [2:0]  m_next_weekday,
    output logic [4:0]  m_next_hour,
    output logic [5:0]  m_next_minute,
    output logic [4:0]  m_next_day,
    output logic [3:0]  m_next_month,
    output logic [13:0] m_next_year,
    output logic        m_no_schedule
);

    localparam int DEPTH = sws_pkg::DAYS * SLOTS_PER_DAY;
    localparam int AW    = $clog2(DEPTH);

    logic             q_valid, q_pop;
    sws_pkg::item_t   q_item;
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [15:0]      ram_wdata, ram_rdata;
    sws_pkg::result_t res;

    sws_front #(.SLOTS_PER_DAY(SLOTS_PER_DAY)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_entry_day, .s_entry_slot,
        .s_entry_value, .s_now_weekday, .s_now_hour, .s_now_minute, .s_date_day,
        .s_date_month, .s_date_year, .s_leap_year,
        .q_valid, .q_item, .q_pop
    );

    sws_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
        .aclk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    sws_back #(.SLOTS_PER_DAY(SLOTS_PER_DAY)) u_back (
        .aclk, .aresetn, .q_valid, .q_item, .q_pop,
        .ram_we, .ram_addr, .ram_wdata, .ram_rdata,
        .m_valid, .m_ready, .m_res(res)
    );

    assign m_power_action = res.action;
    assign m_next_weekday = res.weekday;
    assign m_next_hour    = res.hour;
    assign m_next_minute  = res.minute;
    assign m_next_day     = res.day;
    assign m_next_month   = res.month;
    assign m_next_year    = res.year;
    assign m_no_schedule  = res.no_sched;

endmodule

// File: rtl/core/sws_ram.sv
module sws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 112
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/sws_front.sv
module sws_front #(
    parameter int SLOTS_PER_DAY = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [2:0]          s_entry_day,
    input  logic [3:0]          s_entry_slot,
    input  logic [15:0]         s_entry_value,
    input  logic [2:0]          s_now_weekday,
    input  logic [4:0]          s_now_hour,
    input  logic [5:0]          s_now_minute,
    input  logic [4:0]          s_date_day,
    input  logic [3:0]          s_date_month,
    input  logic [13:0]         s_date_year,
    input  logic                s_leap_year,
    output logic                q_valid,
    output sws_pkg::item_t      q_item,
    input  logic                q_pop
);

    // binary to two BCD digits, value below 64
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [2:0] tens;
        logic [5:0] units;
        tens = 3'd0;
        for (int t = 1; t < 7; t++) begin
            if (v >= 6'(t * 10)) begin
                tens = 3'(t);
            end
        end
        units = v - 6'({tens, 3'b000}) - 6'({tens, 1'b0});
        return {1'b0, tens, units[3:0]};
    endfunction

    sws_pkg::item_t in_item;
    sws_pkg::item_t q_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     cnt_reg;
    logic           push;

    // classify the incoming word
    always_comb begin
        in_item.cmd     = sws_pkg::cmd_t'(s_command);
        in_item.wr_ok   = (int'(s_entry_day) < sws_pkg::DAYS) &&
                          (int'(s_entry_slot) < SLOTS_PER_DAY);
        in_item.day     = s_entry_day;
        in_item.slot    = s_entry_slot;
        in_item.value   = s_entry_value;
        in_item.weekday = s_now_weekday;
        in_item.cur     = {to_bcd({1'b0, s_now_hour}), to_bcd(s_now_minute)};
        in_item.dday    = s_date_day;
        in_item.month   = s_date_month;
        in_item.year    = s_date_year;
        in_item.leap    = s_leap_year;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_reg[rptr_reg];

    // two-word queue to the back end
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop) begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// File: rtl/core/sws_back.sv
module sws_back #(
    parameter int SLOTS_PER_DAY = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  sws_pkg::item_t         q_item,
    output logic                   q_pop,
    output logic                   ram_we,
    output logic [$clog2(sws_pkg::DAYS*SLOTS_PER_DAY)-1:0] ram_addr,
    output logic [15:0]            ram_wdata,
    input  logic [15:0]            ram_rdata,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sws_pkg::result_t       m_res
);

    localparam int DEPTH = sws_pkg::DAYS * SLOTS_PER_DAY;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(SLOTS_PER_DAY + 1);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_SLOT_RD = 9'b000000010,
        ST_SLOT_EV = 9'b000000100,
        ST_NEXT_RD = 9'b000001000,
        ST_NEXT_EV = 9'b000010000,
        ST_DAY_RD  = 9'b000100000,
        ST_DAY_EV  = 9'b001000000,
        ST_DATE    = 9'b010000000,
        ST_OUT     = 9'b100000000
    } state_t;

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
    endfunction

    state_t           state_reg, state_next;
    sws_pkg::item_t   item_reg, item_next;
    sws_pkg::result_t res_reg, res_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [3:0]       d_reg, d_next;
    logic             wrap_reg, wrap_next;
    logic             found1_reg, found1_next;
    logic             stop2_reg, stop2_next;
    logic [2:0]       day_reg, day_next;
    logic [3:0]       ofs_reg, ofs_next;
    logic [15:0]      entry_reg, entry_next;
    logic             m_valid_reg, m_valid_next;
    sws_pkg::result_t out_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             rvld_reg;

    logic [3:0]       rd_day;
    logic [IW-1:0]    rd_slot;
    logic             rd_ok;
    logic             rd_en;
    logic [15:0]      e;
    logic [AW-1:0]    wr_addr;
    logic             f1, s2, sm;
    logic [3:0]       d_first;
    logic [5:0]       dd, mlen;
    logic [4:0]       mm;
    logic [14:0]      yy;
    logic [7:0]       hr8, mn8;

    // table entry seen this cycle; never-written slots read as end marker
    assign e = rvld_reg ? ram_rdata : sws_pkg::ENTRY_END;

    assign wr_addr = AW'(q_item.day) * AW'(SLOTS_PER_DAY) + AW'(q_item.slot);

    // read address: slot scan or first slot of a day
    always_comb begin
        rd_en   = 1'b0;
        rd_day  = {1'b0, item_reg.weekday};
        rd_slot = i_reg;
        if (state_reg == ST_SLOT_RD || state_reg == ST_NEXT_RD) begin
            rd_en = 1'b1;
        end else if (state_reg == ST_DAY_RD) begin
            rd_en   = 1'b1;
            rd_day  = d_reg;
            rd_slot = '0;
        end
        rd_ok = (int'(rd_day) < sws_pkg::DAYS) && (int'(rd_slot) < SLOTS_PER_DAY);
    end

    assign ram_we    = (state_reg == ST_IDLE) && q_valid &&
                       (q_item.cmd == sws_pkg::CMD_WRITE) && q_item.wr_ok;
    assign ram_wdata = q_item.value;
    assign ram_addr  = ram_we ? wr_addr :
                       (rd_ok ? AW'(rd_day) * AW'(SLOTS_PER_DAY) + AW'(rd_slot) : '0);

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = m_valid_reg;
    assign m_res   = out_reg;

    // first day of the other-day search
    assign d_first = 4'(item_reg.weekday) + 4'd1;

    // next alarm date
    always_comb begin
        if (item_reg.month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            mlen = 6'd30;
        end else if (item_reg.month == 4'd2) begin
            mlen = item_reg.leap ? 6'd29 : 6'd28;
        end else begin
            mlen = 6'd31;
        end
        dd = 6'(item_reg.dday) + 6'(ofs_reg);
        mm = 5'(item_reg.month);
        yy = 15'(item_reg.year);
        if (dd > mlen) begin
            dd = dd - mlen;
            mm = mm + 5'd1;
            if (mm > 5'd12) begin
                mm = 5'd1;
                yy = yy + 15'd1;
            end
        end
        if (yy > sws_pkg::YEAR_MAX) begin
            yy = sws_pkg::YEAR_MAX;
        end
        hr8 = from_bcd(entry_reg[15:8]);
        mn8 = from_bcd(entry_reg[7:0]);
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        i_next       = i_reg;
        d_next       = d_reg;
        wrap_next    = wrap_reg;
        found1_next  = found1_reg;
        stop2_next   = stop2_reg;
        day_next     = day_reg;
        ofs_next     = ofs_reg;
        entry_next   = entry_reg;
        m_valid_next = m_valid_reg;
        f1           = 1'b0;
        s2           = 1'b0;
        sm           = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    item_next   = q_item;
                    res_next    = '0;
                    i_next      = '0;
                    found1_next = 1'b0;
                    stop2_next  = 1'b0;
                    if (q_item.cmd == sws_pkg::CMD_ALARM) begin
                        state_next = ST_SLOT_RD;
                    end else if (q_item.cmd == sws_pkg::CMD_POWER) begin
                        res_next.action = sws_pkg::ACT_OFF;
                        state_next      = ST_SLOT_RD;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SLOT_RD: begin
                state_next = ST_SLOT_EV;
            end
            ST_SLOT_EV: begin
                if (item_reg.cmd == sws_pkg::CMD_ALARM) begin
                    if (e == sws_pkg::ENTRY_END) begin
                        res_next.action = sws_pkg::ACT_OFF;
                        state_next      = ST_DAY_RD;
                    end else if (e == item_reg.cur) begin
                        res_next.action = i_reg[0] ? sws_pkg::ACT_OFF : sws_pkg::ACT_ON;
                        i_next          = i_reg + IW'(1);
                        state_next      = (int'(i_reg) == SLOTS_PER_DAY - 1) ?
                                          ST_DAY_RD : ST_NEXT_RD;
                    end else if (int'(i_reg) == SLOTS_PER_DAY - 1) begin
                        state_next = ST_DAY_RD;
                    end else begin
                        i_next     = i_reg + IW'(1);
                        state_next = ST_SLOT_RD;
                    end
                end else begin
                    // power-up: decision scan and same-day scan in one pass
                    f1 = found1_reg;
                    s2 = stop2_reg;
                    if (!found1_reg && e > item_reg.cur) begin
                        f1              = 1'b1;
                        res_next.action = i_reg[0] ? sws_pkg::ACT_ON : sws_pkg::ACT_OFF;
                    end
                    if (!stop2_reg) begin
                        if (e >= sws_pkg::ENTRY_MIDNIGHT) begin
                            s2 = 1'b1;
                        end else if (e > item_reg.cur) begin
                            s2         = 1'b1;
                            sm         = 1'b1;
                            entry_next = e;
                            day_next   = item_reg.weekday;
                            ofs_next   = 4'd0;
                        end
                    end
                    found1_next = f1;
                    stop2_next  = s2;
                    if ((f1 && s2) || int'(i_reg) == SLOTS_PER_DAY - 1) begin
                        state_next = sm ? ST_DATE : ST_DAY_RD;
                    end else begin
                        i_next     = i_reg + IW'(1);
                        state_next = ST_SLOT_RD;
                    end
                end
                if (state_next == ST_DAY_RD) begin
                    if (d_first >= 4'd7) begin
                        d_next    = 4'd0;
                        wrap_next = 1'b1;
                    end else begin
                        d_next    = d_first;
                        wrap_next = 1'b0;
                    end
                end
            end
            ST_NEXT_RD: begin
                state_next = ST_NEXT_EV;
            end
            ST_NEXT_EV: begin
                if (e != sws_pkg::ENTRY_END && e != sws_pkg::ENTRY_MIDNIGHT) begin
                    entry_next = e;
                    day_next   = item_reg.weekday;
                    ofs_next   = 4'd0;
                    state_next = ST_DATE;
                end else begin
                    state_next = ST_DAY_RD;
                    if (d_first >= 4'd7) begin
                        d_next    = 4'd0;
                        wrap_next = 1'b1;
                    end else begin
                        d_next    = d_first;
                        wrap_next = 1'b0;
                    end
                end
            end
            ST_DAY_RD: begin
                state_next = ST_DAY_EV;
            end
            ST_DAY_EV: begin
                if (e != sws_pkg::ENTRY_END && e != sws_pkg::ENTRY_MIDNIGHT) begin
                    entry_next = e;
                    day_next   = d_reg[2:0];
                    ofs_next   = wrap_reg ? 4'd7 - 4'(item_reg.weekday) + d_reg
                                          : d_reg - 4'(item_reg.weekday);
                    state_next = ST_DATE;
                end else if (d_reg == 4'd6) begin
                    if (wrap_reg) begin
                        res_next.no_sched = 1'b1;
                        state_next        = ST_OUT;
                    end else begin
                        d_next     = 4'd0;
                        wrap_next  = 1'b1;
                        state_next = ST_DAY_RD;
                    end
                end else begin
                    d_next     = d_reg + 4'd1;
                    state_next = ST_DAY_RD;
                end
            end
            ST_DATE: begin
                res_next.weekday = day_reg;
                res_next.hour    = hr8[4:0];
                res_next.minute  = mn8[5:0];
                res_next.day     = dd[4:0];
                res_next.month   = mm[3:0];
                res_next.year    = yy[13:0];
                state_next       = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and working registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        i_reg      <= i_next;
        d_reg      <= d_next;
        wrap_reg   <= wrap_next;
        found1_reg <= found1_next;
        stop2_reg  <= stop2_next;
        day_reg    <= day_next;
        ofs_reg    <= ofs_next;
        entry_reg  <= entry_next;
        rvld_reg   <= rd_en && rd_ok && vld_reg[ram_addr];
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            out_reg <= res_reg;
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (ram_we) begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/sws_checker.sv
module sws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_power_action,
    input logic [2:0]  m_next_weekday,
    input logic [4:0]  m_next_hour,
    input logic [5:0]  m_next_minute,
    input logic [4:0]  m_next_day,
    input logic [3:0]  m_next_month,
    input logic [13:0] m_next_year,
    input logic        m_no_schedule
);

    // a stalled result word stays up
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // no schedule means a cleared next alarm
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_schedule |-> m_next_weekday == 3'd0 && m_next_hour == 5'd0 &&
        m_next_minute == 6'd0 && m_next_day == 5'd0 && m_next_month == 4'd0 &&
        m_next_year == 14'd0)
        else $error("next alarm set without schedule");

    // year saturates, action code in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_next_year <= 14'd9999 && m_power_action <= sws_pkg::ACT_OFF)
        else $error("result field out of range");

    // reset empties the output
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind weekly_schedule_switch sws_checker u_sws_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [2:0]  s_entry_day = '0;
    logic [3:0]  s_entry_slot = '0;
    logic [15:0] s_entry_value = '0;
    logic [2:0]  s_now_weekday = '0;
    logic [4:0]  s_now_hour = '0;
    logic [5:0]  s_now_minute = '0;
    logic [4:0]  s_date_day = '0;
    logic [3:0]  s_date_month = '0;
    logic [13:0] s_date_year = '0;
    logic        s_leap_year = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_power_action;
    logic [2:0]  m_next_weekday;
    logic [4:0]  m_next_hour;
    logic [5:0]  m_next_minute;
    logic [4:0]  m_next_day;
    logic [3:0]  m_next_month;
    logic [13:0] m_next_year;
    logic        m_no_schedule;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  eday;
        logic [3:0]  eslot;
        logic [15:0] evalue;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [4:0]  dday;
        logic [3:0]  month;
        logic [13:0] year;
        logic        leap;
    } sched_cmd_t;

    weekly_schedule_switch #(.SLOTS_PER_DAY(SLOTS)) uut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // shadow copy of the weekly table
    logic [15:0]      shadow_table [sws_pkg::DAYS*SLOTS];
    sws_pkg::result_t expected_words [$];
    int               mismatches = 0;
    int               idle_cycles = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    function automatic logic [15:0] shadow_entry(int d, int s);
        if (d >= sws_pkg::DAYS || s >= SLOTS) return sws_pkg::ENTRY_END;
        return shadow_table[d*SLOTS + s];
    endfunction

    function automatic logic [7:0] bin2bcd(int v);
        return 8'(((v / 10) << 4) + (v % 10));
    endfunction

    function automatic int bcd2bin(logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function automatic bit starts_valid(int d);
        logic [15:0] e;
        e = shadow_entry(d, 0);
        return e != sws_pkg::ENTRY_END && e != sws_pkg::ENTRY_MIDNIGHT;
    endfunction

    // apply one command word to the shadow table and work out its result word
    function automatic sws_pkg::result_t schedule_predict(sched_cmd_t c);
        sws_pkg::result_t r;
        int wk, nday, ofs, dd, mm, yy, mlen;
        logic [15:0] cur, e, n, nentry;
        bit same, found;
        r = '0;
        wk = c.wday;
        cur = {bin2bcd(c.hour), bin2bcd(c.minute)};
        same = 0;
        found = 0;
        nentry = '0;
        nday = wk;
        ofs = 0;
        if (c.cmd == sws_pkg::CMD_WRITE) begin
            if (c.eday < sws_pkg::DAYS && c.eslot < SLOTS)
                shadow_table[c.eday*SLOTS + c.eslot] = c.evalue;
            return r;
        end
        if (c.cmd == sws_pkg::CMD_NOP) return r;
        if (c.cmd == sws_pkg::CMD_ALARM) begin
            r.action = sws_pkg::ACT_NONE;
            for (int i = 0; i < SLOTS; i++) begin
                e = shadow_entry(wk, i);
                if (e == sws_pkg::ENTRY_END) begin
                    r.action = sws_pkg::ACT_OFF;
                    break;
                end
                if (e == cur) begin
                    n = shadow_entry(wk, i + 1);
                    r.action = i[0] ? sws_pkg::ACT_OFF : sws_pkg::ACT_ON;
                    if (n != sws_pkg::ENTRY_END && n != sws_pkg::ENTRY_MIDNIGHT) begin
                        same = 1;
                        nentry = n;
                    end
                    break;
                end
            end
        end else begin
            r.action = sws_pkg::ACT_OFF;
            for (int i = 0; i < SLOTS; i++) begin
                if (shadow_entry(wk, i) > cur) begin
                    r.action = i[0] ? sws_pkg::ACT_ON : sws_pkg::ACT_OFF;
                    break;
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                e = shadow_entry(wk, i);
                if (e >= sws_pkg::ENTRY_MIDNIGHT) break;
                if (e > cur) begin
                    same = 1;
                    nentry = e;
                    break;
                end
            end
        end
        if (!same) begin
            for (int d = wk + 1; d < sws_pkg::DAYS && !found; d++) begin
                if (starts_valid(d)) begin
                    found = 1;
                    nday = d;
                    ofs = d - wk;
                end
            end
            for (int d = 0; d < sws_pkg::DAYS && !found; d++) begin
                if (starts_valid(d)) begin
                    found = 1;
                    nday = d;
                    ofs = 7 - wk + d;
                end
            end
            if (!found) begin
                r.no_sched = 1'b1;
                return r;
            end
            nentry = shadow_entry(nday, 0);
        end
        dd = c.dday;
        mm = c.month;
        yy = c.year;
        case (mm)
            4, 6, 9, 11: mlen = 30;
            2: mlen = c.leap ? 29 : 28;
            default: mlen = 31;
        endcase
        dd += ofs;
        if (dd > mlen) begin
            dd -= mlen;
            mm++;
            if (mm > 12) begin
                mm = 1;
                yy++;
            end
        end
        if (yy > 9999) yy = 9999;
        r.weekday = 3'(nday);
        r.hour = 5'(bcd2bin(nentry[15:8]));
        r.minute = 6'(bcd2bin(nentry[7:0]));
        r.day = 5'(dd);
        r.month = 4'(mm);
        r.year = 14'(yy);
        return r;
    endfunction

    // drive one word and wait for it to be taken; valid drops between words only for random idle gaps
    task automatic send_word(sched_cmd_t c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        {s_command, s_entry_day, s_entry_slot, s_entry_value, s_now_weekday, s_now_hour,
         s_now_minute, s_date_day, s_date_month, s_date_year, s_leap_year} <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(schedule_predict(c));
        @(negedge aclk);
    endtask

    function automatic sched_cmd_t random_time(sched_cmd_t c);
        c.wday = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6));
        c.hour = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(23));
        c.minute = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
        c.dday = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(31, 1));
        c.month = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12, 1));
        c.year = ($urandom_range(4) == 0) ? 14'($urandom) : 14'($urandom_range(9999));
        c.leap = 1'($urandom);
        return c;
    endfunction

    function automatic logic [15:0] random_entry();
        case ($urandom_range(9))
            0: return sws_pkg::ENTRY_END;
            1: return sws_pkg::ENTRY_MIDNIGHT;
            2: return 16'($urandom);
            default: return {bin2bcd($urandom_range(23)), bin2bcd($urandom_range(59))};
        endcase
    endfunction

    // result side: random stall and compare
    always @(negedge aclk) begin
        m_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge aclk) begin
        sws_pkg::result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{sws_pkg::action_t'(m_power_action), m_next_weekday, m_next_hour,
                    m_next_minute, m_next_day, m_next_month, m_next_year, m_no_schedule};
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL weekly_schedule_switch");
            $finish;
        end
    end

    sched_cmd_t       directed_rows [$];
    sws_pkg::result_t directed_exp [$];
    bit               directed_chk [$];

    task automatic add_row(sched_cmd_t c, bit chk, sws_pkg::result_t r);
        directed_rows.push_back(c);
        directed_chk.push_back(chk);
        directed_exp.push_back(r);
    endtask

    initial begin
        sched_cmd_t c;
        int phase_len;
        for (int k = 0; k < sws_pkg::DAYS*SLOTS; k++) shadow_table[k] = sws_pkg::ENTRY_END;

        // directed table: empty table, writes, each command, edge dates
        c = '{sws_pkg::CMD_ALARM, 0, 0, 0, 3, 12, 0, 15, 6, 2020, 0};
        add_row(c, 1, '{sws_pkg::ACT_OFF, 0, 0, 0, 0, 0, 0, 1'b1});
        c = '{sws_pkg::CMD_POWER, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '{sws_pkg::ACT_OFF, 0, 0, 0, 0, 0, 0, 1'b1});
        c = '{sws_pkg::CMD_NOP, 7, 15, 16'hFFFF, 7, 31, 63, 31, 15, 16383, 1};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_WRITE, 7, 0, 16'h0800, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_WRITE, 3, 0, 16'h0800, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_WRITE, 3, 1, 16'h1730, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_WRITE, 3, 2, 16'h2400, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_WRITE, 0, 15, 16'h2359, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_WRITE, 6, 0, 16'h0000, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_ALARM, 0, 0, 0, 3, 8, 0, 31, 12, 9999, 0};
        add_row(c, 0, '0);
        c = '{sws_pkg::CMD_ALARM, 0, 0, 0, 3, 17, 30, 28, 2, 2024, 1};
        add_row(c, 0, '0);
        c = '{sws_pkg::CMD_POWER, 0, 0, 0, 3, 12, 0, 30, 4, 2023, 0};
        add_row(c, 0, '0);
        c = '{sws_pkg::CMD_POWER, 0, 0, 0, 6, 23, 59, 31, 12, 9999, 1};
        add_row(c, 0, '0);
        c = '{sws_pkg::CMD_ALARM, 0, 0, 0, 7, 0, 0, 28, 2, 2023, 0};
        add_row(c, 0, '0);
        c = '{sws_pkg::CMD_POWER, 0, 0, 0, 5, 31, 63, 0, 0, 16383, 1};
        add_row(c, 0, '0);
        c = '{sws_pkg::CMD_WRITE, 1, 0, 16'h9AFF, 0, 0, 0, 1, 1, 0, 0};
        add_row(c, 1, '0);
        c = '{sws_pkg::CMD_ALARM, 0, 0, 0, 0, 23, 59, 30, 11, 1999, 0};
        add_row(c, 0, '0);
        c = '{sws_pkg::CMD_POWER, 0, 0, 0, 0, 0, 0, 29, 2, 2000, 1};
        add_row(c, 0, '0);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k]);
            // typed-in expectation must agree with the predictor too
            if (directed_chk[k] && expected_words[$] != directed_exp[k]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row %0d: expected %p predicted %p",
                             k, directed_exp[k], expected_words[$]);
            end
        end

        // random part in idling phases
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            phase_len = 390;
            for (int k = 0; k < phase_len; k++) begin
                c = random_time('0);
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        c.cmd = sws_pkg::CMD_WRITE;
                        c.eday = ($urandom_range(15) == 0) ? 3'd7 : 3'($urandom_range(6));
                        c.eslot = 4'($urandom);
                        c.evalue = random_entry();
                    end
                    4: c.cmd = ($urandom_range(3) == 0) ? sws_pkg::CMD_NOP : sws_pkg::CMD_POWER;
                    5, 6: c.cmd = sws_pkg::CMD_POWER;
                    default: begin
                        c.cmd = sws_pkg::CMD_ALARM;
                        // hit a stored time most of the time
                        if (c.wday < sws_pkg::DAYS && $urandom_range(3) != 0) begin
                            c.evalue = shadow_entry(c.wday, $urandom_range(SLOTS - 1));
                            if (c.evalue[15:8] < 8'h24 && c.evalue[7:0] < 8'h60) begin
                                c.hour = 5'(bcd2bin(c.evalue[15:8]));
                                c.minute = 6'(bcd2bin(c.evalue[7:0]));
                            end
                        end
                    end
                endcase
                c.evalue = (c.cmd == sws_pkg::CMD_WRITE) ? c.evalue : 16'($urandom);
                if (c.cmd != sws_pkg::CMD_WRITE) begin
                    c.eday = 3'($urandom);
                    c.eslot = 4'($urandom);
                end
                send_word(c);
            end
            // after phase 2, wipe slot 0 of every day so empty-table cases recur
            if (ph == 2) begin
                for (int d = 0; d < sws_pkg::DAYS; d++) begin
                    c = '{sws_pkg::CMD_WRITE, 3'(d), 0, sws_pkg::ENTRY_END, 0, 0, 0, 1, 1, 0, 0};
                    send_word(c);
                end
            end
        end
        s_valid <= 1'b0;

        // drain
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASS weekly_schedule_switch");
        end else begin
            $display("FAIL weekly_schedule_switch");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sws_pkg.sv
rtl/core/sws_ram.sv
rtl/core/sws_front.sv
rtl/core/sws_back.sv
rtl/core/weekly_schedule_switch.sv
rtl/core/sws_checker.sv
tb/tb_top.sv
